>>> hw/rtl/odg_pkg.sv
`default_nettype none

package odg_pkg;

    localparam int FREQ_W = 13;
    localparam int UTIL_W = 11;
    localparam int TEMP_W = 12;
    localparam int CORE_W = 6;
    localparam int REG_COUNT = 7;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    localparam logic [REG_IDX_W-1:0] REG_MIN_FREQ  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MAX_FREQ  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_FREQ_STEP = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_UP_UTIL   = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_DOWN_UTIL = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_CRIT_TEMP = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_RECOV_TEMP = REG_IDX_W'(6);

    localparam logic [FREQ_W-1:0] RST_MIN_FREQ  = FREQ_W'(800);
    localparam logic [FREQ_W-1:0] RST_MAX_FREQ  = FREQ_W'(4000);
    localparam logic [FREQ_W-1:0] RST_FREQ_STEP = FREQ_W'(100);
    localparam logic [UTIL_W-1:0] RST_UP_UTIL   = UTIL_W'(717);
    localparam logic [UTIL_W-1:0] RST_DOWN_UTIL = UTIL_W'(307);
    localparam logic signed [TEMP_W-1:0] RST_CRIT_TEMP  = TEMP_W'(800);
    localparam logic signed [TEMP_W-1:0] RST_RECOV_TEMP = TEMP_W'(780);

    localparam logic [UTIL_W-1:0] UTIL_ONE = UTIL_W'(1024);

    // 80/100 == 4/5; floor(x/5) == (x * 52429) >> 18 for x below 2^18
    localparam int SCALE_IN_W  = FREQ_W + 2;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 18;
    localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'(52429);
    localparam int PROD_W = SCALE_IN_W + RECIP_W;

    typedef struct packed {
        logic [FREQ_W-1:0]        min_freq;
        logic [FREQ_W-1:0]        max_freq;
        logic [FREQ_W-1:0]        freq_step;
        logic [UTIL_W-1:0]        up_util;
        logic [UTIL_W-1:0]        down_util;
        logic signed [TEMP_W-1:0] crit_temp;
        logic signed [TEMP_W-1:0] recov_temp;
    } cfg_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCALE,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/odg_cfg_regs.sv
`default_nettype none

module odg_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [odg_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [odg_pkg::FREQ_W-1:0]    cfg_data,
    output odg_pkg::cfg_t                     cfg
);
    import odg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_FREQ:   cfg_next.min_freq   = cfg_data;
                REG_MAX_FREQ:   cfg_next.max_freq   = cfg_data;
                REG_FREQ_STEP:  cfg_next.freq_step  = cfg_data;
                REG_UP_UTIL:    cfg_next.up_util    = cfg_data[UTIL_W-1:0];
                REG_DOWN_UTIL:  cfg_next.down_util  = cfg_data[UTIL_W-1:0];
                REG_CRIT_TEMP:  cfg_next.crit_temp  = cfg_data[TEMP_W-1:0];
                REG_RECOV_TEMP: cfg_next.recov_temp = cfg_data[TEMP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_freq   <= RST_MIN_FREQ;
            cfg_reg.max_freq   <= RST_MAX_FREQ;
            cfg_reg.freq_step  <= RST_FREQ_STEP;
            cfg_reg.up_util    <= RST_UP_UTIL;
            cfg_reg.down_util  <= RST_DOWN_UTIL;
            cfg_reg.crit_temp  <= RST_CRIT_TEMP;
            cfg_reg.recov_temp <= RST_RECOV_TEMP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/odg_divider.sv
`default_nettype none

module odg_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire odg_pkg::div_ctrl_t        ctrl,
    input  wire logic [odg_pkg::FREQ_W-1:0] dividend,
    input  wire logic [odg_pkg::FREQ_W-1:0] divisor,
    output odg_pkg::div_stat_t             stat,
    output logic [odg_pkg::FREQ_W-1:0]     rem
);
    import odg_pkg::*;

    localparam int DIV_STEPS = FREQ_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0] quo_reg, quo_next;
    logic [FREQ_W-1:0] dvs_reg, dvs_next;

    logic [FREQ_W:0]   trial;
    logic [FREQ_W:0]   diff;
    logic [FREQ_W-1:0] rem_step;

    // one restoring step per cycle, remainder only
    always_comb
    begin
        trial = {rem_reg, quo_reg[FREQ_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_step = diff[FREQ_W-1:0];
        end
        else
        begin
            rem_step = trial[FREQ_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = {quo_reg[FREQ_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem = rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ondemand_dvfs_governor.sv
// min, max and hold decisions go from acceptance through the evaluate state to the
// finish state; when the frequency is scaled down and floored to the step size, the
// scale and divide states come between, where the 13-step serial divider takes the
// remainder by the step size; a new transaction is accepted only while idle
// reset (rst_n, asynchronous): throttle flag cleared, configuration registers to defaults,
// no result pending
`default_nettype none

module ondemand_dvfs_governor (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [odg_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [odg_pkg::FREQ_W-1:0]    cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [odg_pkg::CORE_W-1:0]    core_index,
    input  wire logic signed [odg_pkg::TEMP_W-1:0] peak_temp,
    input  wire logic [odg_pkg::UTIL_W-1:0]    utilization,
    input  wire logic [odg_pkg::FREQ_W-1:0]    old_freq_mhz,
    input  wire logic                         core_active,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [odg_pkg::CORE_W-1:0]         core_id_out,
    output logic [odg_pkg::FREQ_W-1:0]         new_freq_mhz,
    output logic                              throttled
);
    import odg_pkg::*;

    cfg_t      cfg;
    div_ctrl_t div_ctrl;
    div_stat_t div_stat;
    logic [FREQ_W-1:0] div_rem;
    logic [FREQ_W-1:0] step_eff;

    state_t state_reg, state_next;
    logic   thr_reg, thr_next;
    logic   out_valid_reg, out_valid_next;

    logic [CORE_W-1:0] core_reg, core_next;
    logic [UTIL_W-1:0] util_reg, util_next;
    logic [FREQ_W-1:0] old_reg, old_next;
    logic              active_reg, active_next;
    logic [FREQ_W-1:0] scaled_reg, scaled_next;
    logic [FREQ_W-1:0] res_reg, res_next;
    logic [CORE_W-1:0] out_core_reg, out_core_next;
    logic [FREQ_W-1:0] out_freq_reg, out_freq_next;
    logic              out_thr_reg, out_thr_next;

    logic              in_fire;
    logic              out_free;
    logic [PROD_W-1:0] prod;
    logic [FREQ_W-1:0] floored;

    odg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    odg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (scaled_reg),
        .divisor  (step_eff),
        .stat     (div_stat),
        .rem      (div_rem)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign step_eff = (cfg.freq_step == '0) ? FREQ_W'(1) : cfg.freq_step;
    assign prod     = PROD_W'({old_reg, 2'b00}) * PROD_W'(RECIP_FIVE);
    assign floored  = scaled_reg - div_rem;

    always_comb
    begin
        state_next     = state_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg;
        core_next      = core_reg;
        util_next      = util_reg;
        old_next       = old_reg;
        active_next    = active_reg;
        scaled_next    = scaled_reg;
        res_next       = res_reg;
        out_core_next  = out_core_reg;
        out_freq_next  = out_freq_reg;
        out_thr_next   = out_thr_reg;
        div_ctrl.start = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // hysteresis: above critical wins over below recovered
                    if (peak_temp > cfg.crit_temp)
                    begin
                        thr_next = 1'b1;
                    end
                    else if (peak_temp < cfg.recov_temp)
                    begin
                        thr_next = 1'b0;
                    end
                    core_next   = core_index;
                    util_next   = (utilization > UTIL_ONE) ? UTIL_ONE : utilization;
                    old_next    = old_freq_mhz;
                    active_next = core_active;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (thr_reg || !active_reg)
                begin
                    res_next   = cfg.min_freq;
                    state_next = ST_FIN;
                end
                else if (util_reg > cfg.up_util)
                begin
                    res_next   = cfg.max_freq;
                    state_next = ST_FIN;
                end
                else if ((util_reg < cfg.down_util) && (old_reg != cfg.min_freq))
                begin
                    scaled_next = prod[RECIP_SHIFT +: FREQ_W];
                    state_next  = ST_SCALE;
                end
                else
                begin
                    res_next   = old_reg;
                    state_next = ST_FIN;
                end
            end
            ST_SCALE:
            begin
                div_ctrl.start = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next   = (floored < cfg.min_freq) ? cfg.min_freq : floored;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_core_next  = core_reg;
                    out_freq_next  = res_reg;
                    out_thr_next   = thr_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        core_reg     <= core_next;
        util_reg     <= util_next;
        old_reg      <= old_next;
        active_reg   <= active_next;
        scaled_reg   <= scaled_next;
        res_reg      <= res_next;
        out_core_reg <= out_core_next;
        out_freq_reg <= out_freq_next;
        out_thr_reg  <= out_thr_next;
    end

    assign out_valid    = out_valid_reg;
    assign core_id_out  = out_core_reg;
    assign new_freq_mhz = out_freq_reg;
    assign throttled    = out_thr_reg;

    // divider only runs for the scaling path
    a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && out_free) |=> (out_valid && (state_reg == ST_IDLE)))
        else $error("finished transaction not presented");

endmodule

`default_nettype wire
